/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds at an edge, consequent holds at the same edge
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds at an edge, consequent holds at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/swms_pkg.sv */
package swms_pkg;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 128;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_IDX_W   = 3;

    localparam int WORD_W   = 64;
    localparam int RID_W    = 6;
    localparam int GID_W    = 4;
    localparam int MASK_W   = 16;
    localparam int SPACES_W = 6;

    localparam int CELL_W    = 12;
    localparam int SCORE_W   = 17;
    localparam int MISM_W    = 6;
    localparam int TOTAL_W   = 40;
    localparam int CNT_W     = 32;
    localparam int GROUP_LEN = 8;
    localparam int PART_W    = 15;
    localparam int PMISM_W   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_ROW_0   = 3'd0,
        CFG_SCORE_ROW_1   = 3'd1,
        CFG_SCORE_ROW_2   = 3'd2,
        CFG_SCORE_ROW_3   = 3'd3,
        CFG_MISMATCH_MASK = 3'd4,
        CFG_THRESHOLD     = 3'd5,
        CFG_SPACES        = 3'd6
    } t_cfg_idx;

    typedef logic [3:0][CFG_DATA_W-1:0] t_score_rows;

    typedef struct packed {
        t_score_rows         rows;
        logic [MASK_W-1:0]   mask;
        logic [SPACES_W-1:0] spaces;
    } t_score_cfg;

    typedef struct packed {
        logic signed [TOTAL_W-1:0] score;
        logic [CNT_W-1:0]          mism;
        logic [CNT_W-1:0]          count;
    } t_acc;

    function automatic logic signed [CELL_W-1:0] cell_score(
        input t_score_rows rows,
        input logic [1:0]  g,
        input logic [1:0]  r
    );
        logic [CFG_DATA_W-1:0] row;
        row = rows[g];
        return signed'(row[CELL_W*r +: CELL_W]);
    endfunction

endpackage

/* hdl/swms_score_unit.sv */
module swms_score_unit #(
    parameter int MAX_SPACES = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [swms_pkg::WORD_W-1:0]           i_genome_word,
    input  logic [swms_pkg::WORD_W-1:0]           i_read_word,
    input  swms_pkg::t_score_cfg                  i_cfg,
    output logic signed [swms_pkg::SCORE_W-1:0]   o_score,
    output logic [swms_pkg::MISM_W-1:0]           o_mismatches
);

    localparam int NUM_GROUPS =
        (MAX_SPACES + swms_pkg::GROUP_LEN - 1) / swms_pkg::GROUP_LEN;

    logic [swms_pkg::SPACES_W-1:0]        w_spaces;
    logic signed [swms_pkg::PART_W-1:0]   n_part_score [NUM_GROUPS];
    logic signed [swms_pkg::PART_W-1:0]   r_part_score [NUM_GROUPS];
    logic [swms_pkg::PMISM_W-1:0]         n_part_mism  [NUM_GROUPS];
    logic [swms_pkg::PMISM_W-1:0]         r_part_mism  [NUM_GROUPS];
    logic signed [swms_pkg::SCORE_W-1:0]  n_score;
    logic [swms_pkg::MISM_W-1:0]          n_mism;

    // positions beyond the lane count are not compared
    always_comb begin
        if (i_cfg.spaces > swms_pkg::SPACES_W'(MAX_SPACES)) begin
            w_spaces = swms_pkg::SPACES_W'(MAX_SPACES);
        end else begin
            w_spaces = i_cfg.spaces;
        end
    end

    // lane lookup and partial sums, one group of eight positions each
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_part_score[g] = '0;
            n_part_mism[g]  = '0;
            for (int j = 0; j < swms_pkg::GROUP_LEN; j++) begin
                if ((g * swms_pkg::GROUP_LEN + j < MAX_SPACES) &&
                    (swms_pkg::SPACES_W'(g * swms_pkg::GROUP_LEN + j) < w_spaces)) begin
                    n_part_score[g] = n_part_score[g] + swms_pkg::PART_W'(
                        swms_pkg::cell_score(i_cfg.rows,
                            i_genome_word[2*(g*swms_pkg::GROUP_LEN+j) +: 2],
                            i_read_word[2*(g*swms_pkg::GROUP_LEN+j) +: 2]));
                    n_part_mism[g] = n_part_mism[g] + swms_pkg::PMISM_W'(
                        i_cfg.mask[{i_genome_word[2*(g*swms_pkg::GROUP_LEN+j) +: 2],
                                    i_read_word[2*(g*swms_pkg::GROUP_LEN+j) +: 2]}]);
                end
            end
        end
    end

    // final sum over the group partials
    always_comb begin
        n_score = '0;
        n_mism  = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_score = n_score + swms_pkg::SCORE_W'(r_part_score[g]);
            n_mism  = n_mism + swms_pkg::MISM_W'(r_part_mism[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_part_score[g] <= n_part_score[g];
                r_part_mism[g]  <= n_part_mism[g];
            end
            o_score      <= n_score;
            o_mismatches <= n_mism;
        end
    end

endmodule

/* hdl/spaced_word_match_scorer_core.sv */
// throughput: one transaction per cycle while no result waits unread and clearing is done;
//   the accumulator memory has one read and one write port and a read-modify-write per item,
//   back-to-back hits on one entry forwarded
// reset (synchronous, active low): config registers to defaults, then a clearing pass
//   zeroes all NUM_READS*NUM_GENOMES accumulators (1024 by default), input not ready
module spaced_word_match_scorer_core #(
    parameter int MAX_SPACES  = 32,
    parameter int NUM_READS   = 64,
    parameter int NUM_GENOMES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [swms_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [swms_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // genome_word[63:0], read_word[127:64], read_id[133:128], genome_id[137:134], zero pad
    input  logic [swms_pkg::IN_TDATA_W-1:0]      s_axis_tdata,

    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // word_score[16:0], word_mismatches[22:17], accepted[23], pair_score_total[63:24],
    // pair_mismatch_total[95:64], pair_match_count[127:96]
    output logic [swms_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int DEPTH  = NUM_READS * NUM_GENOMES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    swms_pkg::t_score_rows                  r_score_rows;
    logic [swms_pkg::MASK_W-1:0]            r_mask;
    logic signed [swms_pkg::SCORE_W-1:0]    r_threshold;
    logic [swms_pkg::SPACES_W-1:0]          r_spaces;
    swms_pkg::t_score_cfg                   w_score_cfg;

    // input unpack
    logic [swms_pkg::WORD_W-1:0]            w_genome_word;
    logic [swms_pkg::WORD_W-1:0]            w_read_word;
    logic [swms_pkg::RID_W-1:0]             w_read_id;
    logic [swms_pkg::GID_W-1:0]             w_genome_id;
    logic                                   w_in_range;
    logic [ADDR_W-1:0]                      w_addr0;

    // pipeline control
    logic                                   w_en;
    logic                                   r_v1;
    logic                                   r_v2;
    logic                                   r_inr1;
    logic                                   r_inr2;
    logic [ADDR_W-1:0]                      r_addr1;
    logic [ADDR_W-1:0]                      r_addr2;

    // scoring pipeline results, aligned with stage 2
    logic signed [swms_pkg::SCORE_W-1:0]    w_score;
    logic [swms_pkg::MISM_W-1:0]            w_mism;

    // accumulator memory and forwarding
    swms_pkg::t_acc                         r_mem [DEPTH];
    swms_pkg::t_acc                         r_rd_data;
    logic                                   r_fwd_valid;
    logic [ADDR_W-1:0]                      r_fwd_addr;
    swms_pkg::t_acc                         r_fwd_data;
    swms_pkg::t_acc                         w_cur;
    swms_pkg::t_acc                         w_new;
    swms_pkg::t_acc                         w_show;
    logic signed [swms_pkg::TOTAL_W:0]      w_score_sum;
    logic [swms_pkg::CNT_W:0]               w_mism_sum;
    logic                                   w_pass;
    logic                                   w_acc;
    logic                                   w_upd;

    // memory write port
    logic                                   w_we;
    logic [ADDR_W-1:0]                      w_waddr;
    swms_pkg::t_acc                         w_wdata;

    // clearing pass
    logic                                   r_clr_done;
    logic [ADDR_W-1:0]                      r_clr_addr;

    // output register
    logic                                   r_out_valid;
    logic [swms_pkg::OUT_TDATA_W-1:0]       r_out_data;

    // ---------------------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_rows <= '0;
            r_mask       <= swms_pkg::MASK_W'(16'h7BDE);
            r_threshold  <= '0;
            r_spaces     <= swms_pkg::SPACES_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                swms_pkg::CFG_SCORE_ROW_0:   r_score_rows[0] <= i_cfg_data;
                swms_pkg::CFG_SCORE_ROW_1:   r_score_rows[1] <= i_cfg_data;
                swms_pkg::CFG_SCORE_ROW_2:   r_score_rows[2] <= i_cfg_data;
                swms_pkg::CFG_SCORE_ROW_3:   r_score_rows[3] <= i_cfg_data;
                swms_pkg::CFG_MISMATCH_MASK: r_mask <= i_cfg_data[swms_pkg::MASK_W-1:0];
                swms_pkg::CFG_THRESHOLD:     r_threshold <= i_cfg_data[swms_pkg::SCORE_W-1:0];
                swms_pkg::CFG_SPACES:        r_spaces <= i_cfg_data[swms_pkg::SPACES_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign w_score_cfg = '{rows: r_score_rows, mask: r_mask, spaces: r_spaces};

    // ---------------------------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------------------------
    assign w_genome_word = s_axis_tdata[63:0];
    assign w_read_word   = s_axis_tdata[127:64];
    assign w_read_id     = s_axis_tdata[133:128];
    assign w_genome_id   = s_axis_tdata[137:134];

    // ids outside the table accumulate nothing and report zero totals
    assign w_in_range = (32'(w_read_id) < NUM_READS) && (32'(w_genome_id) < NUM_GENOMES);
    assign w_addr0    = ADDR_W'(32'(w_read_id) * NUM_GENOMES + 32'(w_genome_id));

    // whole pipeline advances together; it freezes only while a result waits unread
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en && r_clr_done;

    // two-stage score and mismatch sum over the lanes
    swms_score_unit #(
        .MAX_SPACES (MAX_SPACES)
    ) u_score (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_genome_word (w_genome_word),
        .i_read_word   (w_read_word),
        .i_cfg         (w_score_cfg),
        .o_score       (w_score),
        .o_mismatches  (w_mism)
    );

    // stage valids and id tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid && s_axis_tready;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_addr1 <= w_addr0;
            r_inr1  <= w_in_range;
            r_addr2 <= r_addr1;
            r_inr2  <= r_inr1;
        end
    end

    // ---------------------------------------------------------------------------------
    // accumulator read-modify-write in stage 2
    // ---------------------------------------------------------------------------------
    // the memory read for the next item happens at the same edge as this item's write,
    // so an entry written by the item just ahead comes from the forwarding register
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_addr2)) begin
            w_cur = r_fwd_data;
        end else begin
            w_cur = r_rd_data;
        end
    end

    assign w_pass = w_score > r_threshold;
    assign w_acc  = r_inr2 && w_pass;
    assign w_upd  = w_en && r_v2 && w_acc;

    assign w_score_sum = (swms_pkg::TOTAL_W+1)'(w_cur.score) + (swms_pkg::TOTAL_W+1)'(w_score);
    assign w_mism_sum  = {1'b0, w_cur.mism} + (swms_pkg::CNT_W+1)'(w_mism);

    // saturating update
    always_comb begin
        w_new = w_cur;
        if (w_score_sum[swms_pkg::TOTAL_W] != w_score_sum[swms_pkg::TOTAL_W-1]) begin
            w_new.score = w_score_sum[swms_pkg::TOTAL_W]
                        ? {1'b1, {(swms_pkg::TOTAL_W-1){1'b0}}}
                        : {1'b0, {(swms_pkg::TOTAL_W-1){1'b1}}};
        end else begin
            w_new.score = w_score_sum[swms_pkg::TOTAL_W-1:0];
        end
        if (w_mism_sum[swms_pkg::CNT_W]) begin
            w_new.mism = '1;
        end else begin
            w_new.mism = w_mism_sum[swms_pkg::CNT_W-1:0];
        end
        if (!(&w_cur.count)) begin
            w_new.count = w_cur.count + swms_pkg::CNT_W'(1);
        end
    end

    // totals shown in the result
    always_comb begin
        if (!r_inr2) begin
            w_show = '0;
        end else if (w_acc) begin
            w_show = w_new;
        end else begin
            w_show = w_cur;
        end
    end

    // clearing pass owns the write port until done
    always_comb begin
        if (!r_clr_done) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_upd;
            w_waddr = r_addr2;
            w_wdata = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_en) begin
            r_rd_data <= r_mem[r_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (w_en) begin
            r_fwd_valid <= w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fwd_addr <= r_addr2;
            r_fwd_data <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr_addr <= '0;
        end else if (!r_clr_done) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_done <= 1'b1;
            end else begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v2) begin
            r_out_data <= {w_show.count, w_show.mism, w_show.score, w_acc, w_mism, w_score};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* hdl/swms_checker.sv */
`include "assert_macros.svh"

module swms_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [swms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result holds its value
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // leaving reset: clearing pass runs, nothing is in flight
    `ASSERT_SAME(a_reset_quiet, i_clk, i_rst_n, $rose(i_rst_n), !s_axis_tready && !m_axis_tvalid)

    // an accumulated word leaves a nonzero match count
    `ASSERT_SAME(a_acc_count, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[23], m_axis_tdata[127:96] != 32'd0)

    // an accumulated word's mismatches are covered by the saturating total
    `ASSERT_SAME(a_acc_mism, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[23], m_axis_tdata[95:64] >= 32'(m_axis_tdata[22:17]))

endmodule

bind spaced_word_match_scorer_core swms_checker u_swms_checker (.*);
